// File: design/tcfod_pkg.sv
// Shared types and codes for the two-class FIFO with oldest-of-any dequeue.
// No dependencies; imported by every module of the block and by its checker.
`default_nettype none

package tcfod_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_ANY    = 2'd1,
    CMD_CLASS0 = 2'd2,
    CMD_CLASS1 = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_NONE     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Update request into one class FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Occupancy flags of one class FIFO.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

// File: design/tcfod_class_fifo.sv
// One class FIFO: a synchronous memory with a registered head read port,
// plus head and tail pointers with wrap phase. Uses tcfod_pkg.
`default_nettype none

module tcfod_class_fifo #(
  parameter int DEPTH = 16,
  parameter int DW    = 38
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcfod_pkg::fifo_ctrl_t  ctrl_i,
  input  logic [DW-1:0]          wdata_i,
  output tcfod_pkg::fifo_stat_t  stat_o,
  output logic [DW-1:0]          head_data_o
);
  import tcfod_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  logic [IW-1:0] head_idx_q, head_idx_d, tail_idx_q, tail_idx_d;
  logic          head_ph_q, head_ph_d, tail_ph_q, tail_ph_d;

  // Advance pointers, wrapping the index and toggling the phase.
  always_comb begin
    head_idx_d = head_idx_q;
    head_ph_d  = head_ph_q;
    tail_idx_d = tail_idx_q;
    tail_ph_d  = tail_ph_q;
    if (ctrl_i.pop) begin
      if (head_idx_q == LastIdx) begin
        head_idx_d = '0;
        head_ph_d  = ~head_ph_q;
      end else begin
        head_idx_d = head_idx_q + 1'b1;
      end
    end
    if (ctrl_i.push) begin
      if (tail_idx_q == LastIdx) begin
        tail_idx_d = '0;
        tail_ph_d  = ~tail_ph_q;
      end else begin
        tail_idx_d = tail_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q <= '0;
      head_ph_q  <= 1'b0;
      tail_idx_q <= '0;
      tail_ph_q  <= 1'b0;
    end else begin
      head_idx_q <= head_idx_d;
      head_ph_q  <= head_ph_d;
      tail_idx_q <= tail_idx_d;
      tail_ph_q  <= tail_ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_idx_q] <= wdata_i;
    end
    rdata_q <= mem[head_idx_q];
  end

  assign stat_o.empty = (head_idx_q == tail_idx_q) && (head_ph_q == tail_ph_q);
  assign stat_o.full  = (head_idx_q == tail_idx_q) && (head_ph_q != tail_ph_q);
  assign head_data_o  = rdata_q;

endmodule

`default_nettype wire

// File: design/two_class_fifo_oldest_dequeue.sv
// Top level of the two-class FIFO with oldest-of-any dequeue.
// Depends on tcfod_pkg and tcfod_class_fifo.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_ready_o  | command_i, kind_i, payload_i
//   out     | source    | out_valid_o / out_ready_i| status_o, out_kind_o, out_payload_o
//
// For each request word, both class memories load their head entry into the read
// register at the accept edge; the execute cycle compares head stamps, updates
// pointers and writes the memory. The next word is accepted in the cycle after
// execute; no new word is taken while one is held for execute. Execute holds
// while the output register still carries an untaken word. Reset clears pointers,
// stamp counter and handshake state; the memories keep their data.
`default_nettype none

module two_class_fifo_oldest_dequeue #(
  parameter int CLASS_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic               kind_i,
  input  logic signed [31:0] payload_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               out_kind_o,
  output logic signed [31:0] out_payload_o
);
  import tcfod_pkg::*;

  // Stamps wrap modulo four times the class depth.
  localparam int SW = $clog2(4 * CLASS_DEPTH);
  localparam int DW = PAYLOAD_WIDTH + SW;
  localparam logic [SW-1:0] StampLast = SW'(4 * CLASS_DEPTH - 1);
  localparam logic [SW:0]   StampMod  = (SW + 1)'(4 * CLASS_DEPTH);
  localparam logic [SW:0]   StampHalf = (SW + 1)'(2 * CLASS_DEPTH);

  state_e state_q, state_d;

  // Request held from accept until execute.
  cmd_e                     cmd_q;
  logic                     kind_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  logic [SW-1:0] stamp_q, stamp_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic        okind_q, okind_d;
  logic [31:0] opay_q, opay_d;

  fifo_ctrl_t    ctrl0, ctrl1;
  fifo_stat_t    stat0, stat1;
  logic [DW-1:0] head0, head1, wdata;

  logic [63:0] pay_wide;
  logic        out_free, exec;
  logic [SW:0] stamp_diff, stamp_dist;
  logic        pick0, sel, sel_has;
  logic signed [PAYLOAD_WIDTH-1:0] sel_pay;
  logic signed [63:0]              sel_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec       = (state_q == S_EXEC) && out_free;

  // Keep the low payload bits; widths beyond 32 hold zeros above.
  assign pay_wide = {32'b0, payload_i};
  assign wdata    = {stamp_q, pay_q};

  // Class 0 is older when class 1's stamp lies less than half the range ahead.
  always_comb begin
    stamp_diff = {1'b0, head1[DW-1 -: SW]} - {1'b0, head0[DW-1 -: SW]};
    stamp_dist = stamp_diff[SW] ? (stamp_diff + StampMod) : stamp_diff;
    pick0      = (stamp_dist < StampHalf);
  end

  // Choose the class to serve and whether it has a word.
  always_comb begin
    sel     = 1'b0;
    sel_has = 1'b0;
    case (cmd_q)
      CMD_ANY: begin
        if (!stat0.empty && !stat1.empty) begin
          sel     = !pick0;
          sel_has = 1'b1;
        end else if (!stat0.empty) begin
          sel     = 1'b0;
          sel_has = 1'b1;
        end else if (!stat1.empty) begin
          sel     = 1'b1;
          sel_has = 1'b1;
        end
      end
      CMD_CLASS0: begin
        sel     = 1'b0;
        sel_has = !stat0.empty;
      end
      CMD_CLASS1: begin
        sel     = 1'b1;
        sel_has = !stat1.empty;
      end
      default: begin
        sel     = kind_q;
        sel_has = 1'b0;
      end
    endcase
  end

  assign sel_pay = sel ? head1[PAYLOAD_WIDTH-1:0] : head0[PAYLOAD_WIDTH-1:0];
  assign sel_ext = 64'(sel_pay);

  // Next state: accept in idle; in execute, update the FIFOs, the stamp counter and the output register.
  always_comb begin
    state_d     = state_q;
    stamp_d     = stamp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    okind_d     = okind_q;
    opay_d      = opay_q;
    ctrl0       = '0;
    ctrl1       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          okind_d     = 1'b0;
          opay_d      = '0;
          if (cmd_q == CMD_ENQ) begin
            if (kind_q ? stat1.full : stat0.full) begin
              status_d = ST_FULL;
            end else begin
              status_d   = ST_ENQUEUED;
              ctrl0.push = !kind_q;
              ctrl1.push = kind_q;
              stamp_d    = (stamp_q == StampLast) ? '0 : stamp_q + 1'b1;
            end
          end else if (sel_has) begin
            status_d  = ST_REMOVED;
            okind_d   = sel;
            opay_d    = sel_ext[31:0];
            ctrl0.pop = !sel;
            ctrl1.pop = sel;
          end else begin
            status_d = ST_NONE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request word on accept; load the output register on execute.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(command_i);
      kind_q <= kind_i;
      pay_q  <= pay_wide[PAYLOAD_WIDTH-1:0];
    end
    if (exec) begin
      status_q <= status_d;
      okind_q  <= okind_d;
      opay_q   <= opay_d;
    end
  end

  tcfod_class_fifo #(
    .DEPTH (CLASS_DEPTH),
    .DW    (DW)
  ) u_class0 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl0),
    .wdata_i     (wdata),
    .stat_o      (stat0),
    .head_data_o (head0)
  );

  tcfod_class_fifo #(
    .DEPTH (CLASS_DEPTH),
    .DW    (DW)
  ) u_class1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl1),
    .wdata_i     (wdata),
    .stat_o      (stat1),
    .head_data_o (head1)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_kind_o    = okind_q;
  assign out_payload_o = opay_q;

endmodule

`default_nettype wire

// File: design/tcfod_checker.sv
// Port-level checks for the two-class FIFO top level, and the bind that
// attaches them. Depends on tcfod_pkg.
`default_nettype none

module tcfod_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic        out_kind_i,
  input logic [31:0] out_payload_i
);
  import tcfod_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(out_kind_i) && $stable(out_payload_i))
    else $error("stalled result word changed");

  // Only a removal carries class and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_REMOVED) |-> !out_kind_i && (out_payload_i == 32'd0))
    else $error("non-removal word carries data");

  // An accepted request occupies the block for its execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted during execute");

  // A new result appears only after an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without execute cycle");

endmodule

bind two_class_fifo_oldest_dequeue tcfod_checker u_tcfod_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_i      (status_o),
  .out_kind_i    (out_kind_o),
  .out_payload_i (out_payload_o)
);

`default_nettype wire
